>>> sv/pedq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pedq_pkg;

  localparam int PRI_W  = 8;
  localparam int ID_W   = 16;
  localparam int DATA_W = 16;
  localparam int SLOT_W = 3;
  localparam int QD_W   = 5;
  localparam int CFG_W  = 64;
  localparam int CIDX_W = 2;

  typedef enum logic [0:0] {
    OP_POST     = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_PRIORITIES = 2'd0,
    CFG_ENABLE     = 2'd1,
    CFG_DEPTH      = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POST,
    ST_BEST,
    ST_SCAN,
    ST_OUT
  } st_t;

  typedef struct packed {
    op_t                operation;
    logic [SLOT_W-1:0]  task_slot;
    logic [ID_W-1:0]    event_id;
    logic [DATA_W-1:0]  event_data;
  } pedq_in_t;

  typedef struct packed {
    logic               success;
    logic [SLOT_W-1:0]  out_slot;
    logic [ID_W-1:0]    out_event_id;
    logic [DATA_W-1:0]  out_event_data;
  } pedq_out_t;

  typedef struct packed {
    logic enabled;
    logic pending;
    logic pri_eq;
    logic pri_gt;
  } pedq_eval_t;

endpackage

`default_nettype wire

>>> sv/pedq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pedq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/pedq_slot_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module pedq_slot_eval
  import pedq_pkg::*;
#(
  parameter int IW = 4
) (
  input  wire logic             enabled,
  input  wire logic [PRI_W-1:0] pri,
  input  wire logic [PRI_W-1:0] ref_pri,
  input  wire logic [IW-1:0]    head,
  input  wire logic [IW-1:0]    tail,
  input  wire logic             depth_one,
  output pedq_eval_t            eval
);

  localparam logic [IW-1:0] ONE = IW'(1);

  always_comb begin
    eval.enabled = enabled;
    eval.pending = depth_one ? (tail == ONE) : (head != tail);
    eval.pri_eq  = (pri == ref_pri);
    eval.pri_gt  = (pri > ref_pri);
  end

endmodule

`default_nettype wire

>>> sv/priority_event_queue_dispatcher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Post: accept, ring update, then result load into the output register; 1 request at a time.
// Dispatch: one task slot per cycle goes through the shared compare unit, for the
// pass-priority search (skipped while a pass is active) and then for the in-order scan.
// A new request is taken only while idle, so each request is finished first; one is
// also taken while a result waits in the output register.
// Reset (rst_n low, synchronous): clears ring pointers, pass state, output valid and
// config (priorities 0, enable mask 0, depth 16). Event store contents stay undefined.

module priority_event_queue_dispatcher_top
  import pedq_pkg::*;
#(
  parameter int NUM_TASKS   = 8,
  parameter int QUEUE_SLOTS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pedq_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pedq_out_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int SLW   = $clog2(NUM_TASKS);
  localparam int IW    = $clog2(QUEUE_SLOTS);
  localparam int CW    = IW + 1;
  localparam int AW    = SLW + IW;
  localparam int RAM_D = 2 ** AW;
  localparam int RAM_W = ID_W + DATA_W;

  localparam logic [SLW-1:0]    LAST_SLOT = SLW'(NUM_TASKS - 1);
  localparam logic [SLOT_W:0]   NT_SLOT   = (SLOT_W + 1)'(NUM_TASKS);
  localparam logic [QD_W-1:0]   QS_QD     = QD_W'(QUEUE_SLOTS);
  localparam logic [CW-1:0]     QS_CW     = CW'(QUEUE_SLOTS);

  logic [PRI_W-1:0]     pri_r [NUM_TASKS];
  logic [NUM_TASKS-1:0] mask_r;
  logic [QD_W-1:0]      depth_r;

  st_t              state_r, state_nxt;
  pedq_in_t         req_r, req_nxt;
  logic [SLW-1:0]   cnt_r, cnt_nxt;
  logic [PRI_W-1:0] best_r, best_nxt;
  logic             fresh_r, fresh_nxt;
  logic [PRI_W-1:0] pass_pri_r, pass_pri_nxt;
  logic [SLW-1:0]   scan_pos_r, scan_pos_nxt;
  logic             pass_act_r, pass_act_nxt;
  logic [IW-1:0]    head_r [NUM_TASKS];
  logic [IW-1:0]    head_nxt [NUM_TASKS];
  logic [IW-1:0]    tail_r [NUM_TASKS];
  logic [IW-1:0]    tail_nxt [NUM_TASKS];
  logic             res_ok_r, res_ok_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic             res_hit_r, res_hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  pedq_out_t        out_r, out_nxt;

  logic [SLW-1:0]   cur_slot;
  logic [IW-1:0]    head_cur, tail_cur;
  logic [PRI_W-1:0] ref_pri;
  pedq_eval_t       eval;
  logic             depth_one;
  logic [CW-1:0]    depth_eff;
  logic [IW-1:0]    adv_in, adv_out;
  logic [CW-1:0]    adv_sum;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        pri_r[i] <= '0;
      end
      mask_r  <= '0;
      depth_r <= QD_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRIORITIES: begin
          for (int i = 0; i < NUM_TASKS; i++) begin
            pri_r[i] <= cfg_data[PRI_W*i +: PRI_W];
          end
        end
        CFG_ENABLE: mask_r  <= cfg_data[NUM_TASKS-1:0];
        CFG_DEPTH:  depth_r <= cfg_data[QD_W-1:0];
        default: ;
      endcase
    end
  end

  assign depth_one = (depth_r <= QD_W'(1));
  assign depth_eff = (depth_r > QS_QD) ? QS_CW : CW'(depth_r);

  assign cur_slot = (state_r == ST_POST) ? req_r.task_slot[SLW-1:0] : cnt_r;
  assign head_cur = head_r[cur_slot];
  assign tail_cur = tail_r[cur_slot];
  assign ref_pri  = (state_r == ST_BEST) ? best_r : pass_pri_r;

  assign adv_in  = (state_r == ST_POST) ? head_cur : tail_cur;
  assign adv_sum = {1'b0, adv_in} + CW'(1);
  assign adv_out = (adv_sum >= depth_eff) ? '0 : adv_sum[IW-1:0];

  pedq_slot_eval #(
    .IW(IW)
  ) u_eval (
    .enabled  (mask_r[cur_slot]),
    .pri      (pri_r[cur_slot]),
    .ref_pri  (ref_pri),
    .head     (head_cur),
    .tail     (tail_cur),
    .depth_one(depth_one),
    .eval     (eval)
  );

  pedq_ram #(
    .WIDTH(RAM_W),
    .DEPTH(RAM_D)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_wdata = {req_r.event_id, req_r.event_data};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    fresh_nxt     = fresh_r;
    pass_pri_nxt  = pass_pri_r;
    scan_pos_nxt  = scan_pos_r;
    pass_act_nxt  = pass_act_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    res_ok_nxt    = res_ok_r;
    res_slot_nxt  = res_slot_r;
    res_hit_nxt   = res_hit_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    in_stall      = (state_r != ST_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          if (in_data.operation == OP_POST) begin
            state_nxt = ST_POST;
          end else if (pass_act_r) begin
            cnt_nxt   = scan_pos_r;
            fresh_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end else begin
            cnt_nxt   = '0;
            best_nxt  = '0;
            state_nxt = ST_BEST;
          end
        end
      end
      ST_POST: begin
        res_slot_nxt = '0;
        res_hit_nxt  = 1'b0;
        res_ok_nxt   = 1'b0;
        state_nxt    = ST_OUT;
        if ({1'b0, req_r.task_slot} < NT_SLOT) begin
          if (depth_one) begin
            ram_we             = 1'b1;
            ram_waddr          = {cur_slot, IW'(0)};
            head_nxt[cur_slot] = '0;
            tail_nxt[cur_slot] = IW'(1);
            res_ok_nxt         = 1'b1;
          end else if (adv_out != tail_cur) begin
            ram_we             = 1'b1;
            ram_waddr          = {cur_slot, head_cur};
            head_nxt[cur_slot] = adv_out;
            res_ok_nxt         = 1'b1;
          end
        end
      end
      ST_BEST: begin
        if (eval.enabled && eval.pri_gt && eval.pending) begin
          best_nxt = pri_r[cur_slot];
        end
        if (cnt_r == LAST_SLOT) begin
          pass_pri_nxt = best_nxt;
          pass_act_nxt = 1'b1;
          scan_pos_nxt = '0;
          cnt_nxt      = '0;
          fresh_nxt    = 1'b1;
          state_nxt    = ST_SCAN;
        end else begin
          cnt_nxt = cnt_r + SLW'(1);
        end
      end
      ST_SCAN: begin
        if (eval.enabled && eval.pri_eq && eval.pending) begin
          scan_pos_nxt = cnt_r;
          ram_re       = 1'b1;
          if (depth_one) begin
            ram_raddr          = {cnt_r, IW'(0)};
            tail_nxt[cur_slot] = '0;
          end else begin
            ram_raddr          = {cnt_r, tail_cur};
            tail_nxt[cur_slot] = adv_out;
          end
          res_ok_nxt   = 1'b1;
          res_hit_nxt  = 1'b1;
          res_slot_nxt = SLOT_W'(cnt_r);
          state_nxt    = ST_OUT;
        end else if (cnt_r == LAST_SLOT) begin
          pass_act_nxt = 1'b0;
          scan_pos_nxt = '0;
          if (fresh_r) begin
            res_ok_nxt   = 1'b0;
            res_hit_nxt  = 1'b0;
            res_slot_nxt = '0;
            state_nxt    = ST_OUT;
          end else begin
            cnt_nxt   = '0;
            best_nxt  = '0;
            state_nxt = ST_BEST;
          end
        end else begin
          cnt_nxt = cnt_r + SLW'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.success        = res_ok_r;
          out_nxt.out_slot       = res_slot_r;
          out_nxt.out_event_id   = res_hit_r ? ram_rdata[RAM_W-1:DATA_W] : '0;
          out_nxt.out_event_data = res_hit_r ? ram_rdata[DATA_W-1:0] : '0;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      best_r      <= '0;
      fresh_r     <= 1'b0;
      pass_pri_r  <= '0;
      scan_pos_r  <= '0;
      pass_act_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      best_r      <= best_nxt;
      fresh_r     <= fresh_nxt;
      pass_pri_r  <= pass_pri_nxt;
      scan_pos_r  <= scan_pos_nxt;
      pass_act_r  <= pass_act_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    res_hit_r  <= res_hit_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, head_cur} < QS_CW) && ({1'b0, tail_cur} < QS_CW))
    else $error("ring pointer beyond queue size");

  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) && ($past(state_r) != ST_OUT) |->
      ($past(state_r) == ST_POST) || ($past(state_r) == ST_SCAN))
    else $error("result stage entered without work");

  a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BEST) && (cnt_r == LAST_SLOT) |=> pass_act_r && (state_r == ST_SCAN))
    else $error("pass did not start after priority search");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
